// ===== rtl/lrwr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrwr_pkg
// Shared types and constants for the longest distinct run block.
// ----------------------------------------------------------------------------
package lrwr_pkg;

   localparam int VALUE_BITS  = 10;
   localparam int MAX_LEN     = 65536;
   localparam int TABLE_DEPTH = 1 << VALUE_BITS;
   localparam int POS_BITS    = $clog2(MAX_LEN);
   localparam int LEN_BITS    = 17;
   localparam int EPOCH_BITS  = 10;

   localparam logic [EPOCH_BITS-1:0] EPOCH_MAX = {EPOCH_BITS{1'b1}};
   localparam logic [EPOCH_BITS-1:0] EPOCH_CLEAR = '0;
   localparam logic [POS_BITS:0] MAX_LEN_C = (POS_BITS + 1)'(MAX_LEN);

   typedef struct packed {
      logic [VALUE_BITS-1:0] item_value;
      logic                  first_of_sequence;
      logic                  last_of_sequence;
   } req_type;

   typedef struct packed {
      logic [LEN_BITS-1:0] run_length;
      logic [LEN_BITS-1:0] best_length;
      logic                sequence_done;
      logic                overflow;
   } rsp_type;

   // One table entry: sequence tag and last position of the value
   typedef struct packed {
      logic [EPOCH_BITS-1:0] epoch;
      logic [POS_BITS-1:0]   pos;
   } entry_type;

   localparam int ENT_BITS = $bits(entry_type);

endpackage

// ===== rtl/lrwr_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrwr_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lrwr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/longest_run_without_repeat_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// longest_run_without_repeat_core
// Streaming longest run of distinct values, one table lookup per request.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item per request (value, first and last markers).
//   rsp_* returns one result per request, in order: current run, best run,
//   sequence done and overflow.
//   A request is accepted when req_valid and req_ready are high; it is held
//   in the lookup stage and its result then in the output register. One
//   request per clock is sustained unless the output stalls or the table is
//   clearing: the table is read at acceptance, written as the lookup stage
//   moves; the last write is forwarded to a back-to-back same-value request.
//   Seen flags are sequence tags kept in the table. After reset, and once
//   every 1023 sequence starts before the next one, a clearing pass rewrites
//   all 1024 table entries; req_ready stays low meanwhile.
//   When rsp_ready is low, the result is held, one more request may be taken
//   into the lookup stage, and req_ready then drops until the output moves.
// ----------------------------------------------------------------------------
module longest_run_without_repeat_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lrwr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lrwr_pkg::rsp_type rsp_data
);

   // lookup stage
   logic                                s1_valid_ff, s1_valid_in;
   lrwr_pkg::req_type                   s1_req_ff;
   // sequence state
   logic                                seq_open_ff, seq_open_in;
   logic [lrwr_pkg::EPOCH_BITS-1:0]     epoch_ff, epoch_in;
   logic [lrwr_pkg::POS_BITS-1:0]       pos_ff, pos_in;
   logic [lrwr_pkg::POS_BITS-1:0]       bound_ff, bound_in;
   logic [lrwr_pkg::LEN_BITS-1:0]       run_ff, run_in;
   logic [lrwr_pkg::LEN_BITS-1:0]       best_ff, best_in;
   logic                                ovf_ff, ovf_in;
   // output register
   logic                                rsp_valid_ff, rsp_valid_in;
   lrwr_pkg::rsp_type                   rsp_data_ff;
   // last table write, for forwarding
   logic                                fwd_valid_ff, fwd_valid_in;
   logic [lrwr_pkg::VALUE_BITS-1:0]     fwd_addr_ff;
   lrwr_pkg::entry_type                 fwd_data_ff;
   // clearing pass
   logic                                clear_busy_ff, clear_busy_in;
   logic [lrwr_pkg::VALUE_BITS-1:0]     clear_idx_ff, clear_idx_in;

   logic                                accept, s1_move, start, need_clear;
   logic                                start_in_req, seq_open_after;
   logic [lrwr_pkg::EPOCH_BITS-1:0]     epoch_after;
   logic                                clear_start;
   lrwr_pkg::entry_type                 rd_entry, entry;
   logic                                seen, entry_wr;
   logic [lrwr_pkg::POS_BITS-1:0]       next_pos, new_bound;
   logic [lrwr_pkg::POS_BITS:0]         pos_plus;
   logic                                ram_wr_en;
   logic [lrwr_pkg::VALUE_BITS-1:0]     ram_wr_addr;
   lrwr_pkg::entry_type                 ram_wr_data, s1_wr_data;
   logic [lrwr_pkg::ENT_BITS-1:0]       ram_rd_bits;

   lrwr_ram #(
      .WIDTH (lrwr_pkg::ENT_BITS),
      .DEPTH (lrwr_pkg::TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (req_data.item_value),
      .rd_data (ram_rd_bits)
   );

   assign rd_entry = ram_rd_bits;

   // Handshake and clearing control
   always_comb begin
      s1_move        = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
      seq_open_after = s1_valid_ff ? !s1_req_ff.last_of_sequence : seq_open_ff;
      epoch_after    = (s1_valid_ff && (s1_req_ff.first_of_sequence || !seq_open_ff))
                       ? epoch_ff + lrwr_pkg::EPOCH_BITS'(1) : epoch_ff;
      start_in_req   = req_data.first_of_sequence || !seq_open_after;
      need_clear     = req_valid && start_in_req && (epoch_after == lrwr_pkg::EPOCH_MAX);
      req_ready      = !clear_busy_ff && !need_clear && (!s1_valid_ff || s1_move);
      accept         = req_valid && req_ready;
      clear_start    = need_clear && !s1_valid_ff && !clear_busy_ff;
   end

   // Lookup stage: update sequence state from the table entry
   always_comb begin
      entry      = (fwd_valid_ff && (fwd_addr_ff == s1_req_ff.item_value))
                   ? fwd_data_ff : rd_entry;
      start      = s1_req_ff.first_of_sequence || !seq_open_ff;
      seen       = (entry.epoch == epoch_ff);
      pos_plus   = {1'b0, pos_ff} + (lrwr_pkg::POS_BITS + 1)'(1);
      next_pos   = pos_plus[lrwr_pkg::POS_BITS-1:0];
      new_bound  = (entry.pos > bound_ff) ? entry.pos : bound_ff;

      epoch_in   = epoch_ff;
      pos_in     = pos_ff;
      bound_in   = bound_ff;
      run_in     = run_ff;
      best_in    = best_ff;
      ovf_in     = ovf_ff;
      entry_wr   = 1'b0;
      s1_wr_data = entry;

      priority if (start) begin
         epoch_in         = epoch_ff + lrwr_pkg::EPOCH_BITS'(1);
         pos_in           = '0;
         bound_in         = '0;
         run_in           = lrwr_pkg::LEN_BITS'(1);
         best_in          = lrwr_pkg::LEN_BITS'(1);
         ovf_in           = 1'b0;
         entry_wr         = 1'b1;
         s1_wr_data.epoch = epoch_ff + lrwr_pkg::EPOCH_BITS'(1);
         s1_wr_data.pos   = '0;
      end else if (ovf_ff || (pos_plus >= lrwr_pkg::MAX_LEN_C)) begin
         // hold runs and table past the length limit
         ovf_in = 1'b1;
      end else begin
         pos_in = next_pos;
         if (seen) begin
            bound_in = new_bound;
            run_in   = lrwr_pkg::LEN_BITS'(next_pos - new_bound);
         end else begin
            run_in   = run_ff + lrwr_pkg::LEN_BITS'(1);
         end
         if (run_in > best_ff) begin
            best_in = run_in;
         end
         entry_wr         = 1'b1;
         s1_wr_data.epoch = epoch_ff;
         s1_wr_data.pos   = next_pos;
      end
      seq_open_in = !s1_req_ff.last_of_sequence;
   end

   // Table write port: clearing pass or lookup stage
   always_comb begin
      if (clear_busy_ff) begin
         ram_wr_en         = 1'b1;
         ram_wr_addr       = clear_idx_ff;
         ram_wr_data.epoch = lrwr_pkg::EPOCH_CLEAR;
         ram_wr_data.pos   = '0;
      end else begin
         ram_wr_en   = s1_move && entry_wr;
         ram_wr_addr = s1_req_ff.item_value;
         ram_wr_data = s1_wr_data;
      end
   end

   always_comb begin
      s1_valid_in   = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
      rsp_valid_in  = s1_move ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      fwd_valid_in  = fwd_valid_ff;
      clear_busy_in = clear_busy_ff;
      clear_idx_in  = clear_idx_ff;
      if (clear_start) begin
         clear_busy_in = 1'b1;
         clear_idx_in  = '0;
         fwd_valid_in  = 1'b0;
      end else if (clear_busy_ff) begin
         clear_idx_in = clear_idx_ff + lrwr_pkg::VALUE_BITS'(1);
         if (clear_idx_ff == {lrwr_pkg::VALUE_BITS{1'b1}}) begin
            clear_busy_in = 1'b0;
         end
      end else if (s1_move && entry_wr) begin
         fwd_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         fwd_valid_ff  <= 1'b0;
         clear_busy_ff <= 1'b1;
         clear_idx_ff  <= '0;
         seq_open_ff   <= 1'b0;
         epoch_ff      <= lrwr_pkg::EPOCH_CLEAR;
         pos_ff        <= '0;
         bound_ff      <= '0;
         run_ff        <= '0;
         best_ff       <= '0;
         ovf_ff        <= 1'b0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         fwd_valid_ff  <= fwd_valid_in;
         clear_busy_ff <= clear_busy_in;
         clear_idx_ff  <= clear_idx_in;
         if (clear_busy_ff && !clear_busy_in) begin
            epoch_ff <= lrwr_pkg::EPOCH_CLEAR;
         end
         if (s1_move) begin
            seq_open_ff <= seq_open_in;
            epoch_ff    <= epoch_in;
            pos_ff      <= pos_in;
            bound_ff    <= bound_in;
            run_ff      <= run_in;
            best_ff     <= best_in;
            ovf_ff      <= ovf_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_req_ff <= req_data;
      end
      if (s1_move) begin
         rsp_data_ff.run_length    <= run_in;
         rsp_data_ff.best_length   <= best_in;
         rsp_data_ff.sequence_done <= s1_req_ff.last_of_sequence;
         rsp_data_ff.overflow      <= ovf_in;
      end
      if (!clear_busy_ff && s1_move && entry_wr) begin
         fwd_addr_ff <= s1_req_ff.item_value;
         fwd_data_ff <= s1_wr_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      clear_busy_ff |-> !req_ready)
      else $error("request taken during clearing pass");

   a_stage_empty_in_clear: assert property (@(posedge clock) disable iff (reset)
      clear_busy_ff |-> !s1_valid_ff)
      else $error("lookup stage busy during clearing pass");

   a_no_forward_in_clear: assert property (@(posedge clock) disable iff (reset)
      clear_busy_ff |-> !fwd_valid_ff)
      else $error("forwarding live across clearing pass");

   a_epoch_live: assert property (@(posedge clock) disable iff (reset)
      s1_move |=> (epoch_ff != lrwr_pkg::EPOCH_CLEAR))
      else $error("sequence running on the cleared tag");

   a_best_covers_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.best_length >= rsp_data_ff.run_length))
      else $error("best run shorter than current run");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the longest distinct run core. Requests go in over
// a valid/ready channel. A predictor mirrors the run, best-run and overflow
// tracking, and every response is compared field by field with the oldest
// prediction. The directed items come first. Random sequences follow under
// several idling mixes, then a train of short sequences with idling on both sides.
// ----------------------------------------------------------------------------
module testbench;

   localparam int QUIET_LIMIT = 20000;
   localparam int TAIL_CYCLES = 16;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   lrwr_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   lrwr_pkg::rsp_type rsp_data;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int mismatch_count = 0;
   int quiet_cycles = 0;

   lrwr_pkg::rsp_type pending_runs [$];

   // Predictor state
   bit          run_seen [lrwr_pkg::TABLE_DEPTH];
   int unsigned run_last_pos [lrwr_pkg::TABLE_DEPTH];
   int unsigned run_pos = 0;
   int unsigned run_bound = 0;
   int unsigned run_cur = 0;
   int unsigned run_best = 0;
   bit          run_overflow = 1'b0;
   bit          run_open = 1'b0;

   longest_run_without_repeat_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic lrwr_pkg::rsp_type predict_run(lrwr_pkg::req_type r);
      lrwr_pkg::rsp_type res;
      int unsigned       v;
      int unsigned       i;
      int unsigned       p;
      v = r.item_value;
      if (r.first_of_sequence || !run_open) begin
         foreach (run_seen[k]) run_seen[k] = 1'b0;
         run_pos = 0;
         run_bound = 0;
         run_cur = 1;
         run_best = 1;
         run_overflow = 1'b0;
         run_seen[v] = 1'b1;
         run_last_pos[v] = 0;
      end else if (run_overflow || run_pos + 1 >= lrwr_pkg::MAX_LEN) begin
         // hold everything, only flag the overflow
         run_overflow = 1'b1;
      end else begin
         i = run_pos + 1;
         run_pos = i;
         if (run_seen[v]) begin
            p = run_last_pos[v];
            if (p > run_bound) run_bound = p;
            run_cur = i - run_bound;
         end else begin
            run_seen[v] = 1'b1;
            run_cur = run_cur + 1;
         end
         run_last_pos[v] = i;
         if (run_cur > run_best) run_best = run_cur;
      end
      run_open = !r.last_of_sequence;
      res.run_length = lrwr_pkg::LEN_BITS'(run_cur);
      res.best_length = lrwr_pkg::LEN_BITS'(run_best);
      res.sequence_done = r.last_of_sequence;
      res.overflow = run_overflow;
      return res;
   endfunction

   function automatic void check_run(lrwr_pkg::rsp_type got);
      lrwr_pkg::rsp_type want;
      if (pending_runs.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("%0t: response with no request: run %0d best %0d done %0b ovf %0b",
                     $realtime, got.run_length, got.best_length, got.sequence_done,
                     got.overflow);
         return;
      end
      want = pending_runs.pop_front();
      if (got.run_length !== want.run_length || got.best_length !== want.best_length ||
          got.sequence_done !== want.sequence_done || got.overflow !== want.overflow) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("%0t: mismatch (exp/got): run %0d/%0d best %0d/%0d",
                     $realtime, want.run_length, got.run_length, want.best_length,
                     got.best_length, " done %0b/%0b ovf %0b/%0b",
                     want.sequence_done, got.sequence_done, want.overflow, got.overflow);
      end
   endfunction

   // Predict on each accepted request, check each accepted response
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) pending_runs.push_back(predict_run(req_data));
         if (rsp_valid && rsp_ready) check_run(rsp_data);
      end
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Count cycles with work outstanding and no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (!req_valid && pending_runs.size() == 0)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_item(input logic [lrwr_pkg::VALUE_BITS-1:0] value, input logic first,
                            input logic last);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_data <= '{item_value: value, first_of_sequence: first, last_of_sequence: last};
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic stop_sending();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic set_idling(input int idle_pct, input int stall_pct);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
   endtask

   task automatic test_directed();
      set_idling(0, 0);
      send_item(10'd7, 1'b0, 1'b0);     // no open sequence after reset
      send_item(10'd7, 1'b0, 1'b0);     // back-to-back repeat
      send_item(10'd0, 1'b0, 1'b0);
      send_item(10'd1023, 1'b0, 1'b0);
      send_item(10'd0, 1'b0, 1'b0);
      send_item(10'd1023, 1'b0, 1'b1);  // repeat on the final item
      send_item(10'd3, 1'b0, 1'b0);     // new sequence without a first marker
      send_item(10'd4, 1'b0, 1'b0);
      send_item(10'd5, 1'b0, 1'b0);
      send_item(10'd4, 1'b0, 1'b0);
      send_item(10'd3, 1'b0, 1'b0);     // last position lies below the bound
      send_item(10'd8, 1'b0, 1'b0);
      send_item(10'd6, 1'b1, 1'b0);     // restart inside an open sequence
      send_item(10'd5, 1'b0, 1'b0);     // seen only in the abandoned sequence
      send_item(10'd6, 1'b0, 1'b0);
      send_item(10'd9, 1'b1, 1'b1);     // single-item sequence
      send_item(10'd9, 1'b0, 1'b0);
      send_item(10'd682, 1'b0, 1'b0);
      send_item(10'd341, 1'b0, 1'b0);
      send_item(10'd9, 1'b0, 1'b1);
      stop_sending();
   endtask

   task automatic test_random_sequences(input int budget, input int idle_pct,
                                        input int stall_pct);
      int sent;
      int len;
      int span;
      logic first;
      set_idling(idle_pct, stall_pct);
      sent = 0;
      while (sent < budget) begin
         if ($urandom_range(9) == 0) begin
            // noise: markers at random
            send_item(lrwr_pkg::VALUE_BITS'($urandom), 1'($urandom), 1'($urandom));
            sent++;
         end else begin
            len = $urandom_range(40, 1);
            case ($urandom_range(3))
               0: span = 1;
               1: span = 4;
               2: span = 16;
               default: span = lrwr_pkg::TABLE_DEPTH;
            endcase
            for (int k = 0; k < len; k++) begin
               first = (k == 0) && ($urandom_range(3) != 0);
               send_item(lrwr_pkg::VALUE_BITS'($urandom_range(span - 1)), first,
                         (k == len - 1) && ($urandom_range(3) != 0));
            end
            sent += len;
         end
      end
      stop_sending();
   endtask

   task automatic test_short_sequences();
      int len;
      set_idling(38, 38);
      // frequent restarts on a handful of values
      for (int s = 0; s < 50; s++) begin
         len = $urandom_range(3, 1);
         for (int k = 0; k < len; k++)
            send_item(lrwr_pkg::VALUE_BITS'($urandom_range(3)),
                      (k == 0) && $urandom_range(1), k == len - 1);
      end
      stop_sending();
   endtask

   initial begin
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_sequences(150, 0, 0);
      test_random_sequences(150, 78, 0);
      test_random_sequences(150, 0, 78);
      test_random_sequences(150, 38, 38);
      test_short_sequences();
      set_idling(0, 0);
      while (pending_runs.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/lrwr_pkg.sv
rtl/lrwr_ram.sv
rtl/longest_run_without_repeat_core.sv
tb/sv/testbench.sv
